@@ hw/rtl/mmwf_pkg.sv @@
// Shared types and constants of the median and mean window filter.
package mmwf_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int RES_SLOTS       = 3;
	localparam int CNT_BITS        = 2;
	localparam int MODE_BITS       = 2;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_MEAN     = 2'd0,
		MODE_MEDIAN   = 2'd1,
		MODE_MED_MEAN = 2'd2
	} mode_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]  count;
		logic [RES_SLOTS-1:0] last;
	} res_ctl_t;

endpackage

@@ hw/rtl/mmwf_core.sv @@
// Input register, window state and single-pass computation of the results of one item.
module mmwf_core #(
	parameter int SAMPLE_BITS = mmwf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic [mmwf_pkg::MODE_BITS-1:0]                  mode,
	input  logic                                            in_valid,
	output logic                                            in_stall,
	input  logic [SAMPLE_BITS-1:0]                          sample,
	input  logic                                            is_final,
	input  logic                                            load_ready,
	output logic                                            load_valid,
	output mmwf_pkg::res_ctl_t                              res_ctl,
	output logic [mmwf_pkg::RES_SLOTS-1:0][SAMPLE_BITS-1:0] res_val
);

	localparam int W = SAMPLE_BITS;
	localparam int NS = mmwf_pkg::RES_SLOTS;
	localparam logic [W:0] DIV3_MUL = (W+1)'(((66'd1 << (W + 2)) + 66'd2) / 66'd3);

	function automatic logic signed [W-1:0] max2(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [W-1:0] med3(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b, input logic signed [W-1:0] c);
		logic signed [W-1:0] hi;
		logic signed [W-1:0] lo;
		logic signed [W-1:0] m;
		hi = (a > b) ? a : b;
		lo = (a < b) ? a : b;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

	function automatic logic signed [W-1:0] mean2(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [W:0] s;
		logic [W:0] t;
		s = (W+1)'(a) + (W+1)'(b);
		t = s + (W+1)'(s[W]);
		return t[W:1];
	endfunction

	function automatic logic signed [W-1:0] mean3(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b, input logic signed [W-1:0] c);
		logic signed [W+1:0] s;
		logic [W:0] u;
		logic [2*W+1:0] p;
		logic [W-1:0] q;
		s = (W+2)'(a) + (W+2)'(b) + (W+2)'(c);
		u = s[W+1] ? (W+1)'(-s) : (W+1)'(s);
		p = (2*W+2)'(u) * (2*W+2)'(DIV3_MUL);
		q = p[2*W+1:W+2];
		return s[W+1] ? -q : q;
	endfunction

	logic                       v_s1;
	logic signed [W-1:0]        x_s1;
	logic                       fin_s1;
	logic                       advance;
	logic                       accept;

	logic [1:0]                 raw_seen_q;
	logic signed [W-1:0]        raw0_q;
	logic signed [W-1:0]        raw1_q;
	logic [1:0]                 med_seen_q;
	logic signed [W-1:0]        med0_q;
	logic signed [W-1:0]        med1_q;

	logic [1:0]                 raw_seen_d;
	logic signed [W-1:0]        raw0_d;
	logic signed [W-1:0]        raw1_d;
	logic [1:0]                 med_seen_d;
	logic signed [W-1:0]        med0_d;
	logic signed [W-1:0]        med1_d;

	always_comb begin
		advance    = v_s1 && load_ready;
		in_stall   = v_s1 && !load_ready;
		accept     = in_valid && !in_stall;
		load_valid = v_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= sample;
			fin_s1 <= is_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_seen_q <= '0;
			raw0_q     <= '0;
			raw1_q     <= '0;
			med_seen_q <= '0;
			med0_q     <= '0;
			med1_q     <= '0;
		end else if (advance) begin
			raw_seen_q <= raw_seen_d;
			raw0_q     <= raw0_d;
			raw1_q     <= raw1_d;
			med_seen_q <= med_seen_d;
			med0_q     <= med0_d;
			med1_q     <= med1_d;
		end
	end

	logic                       a_ok;
	logic [1:0]                 a_cnt;
	logic signed [W-1:0]        a0;
	logic signed [W-1:0]        a1;
	logic signed [W-1:0]        a2;
	logic                       a_last;
	logic                       b_ok;
	logic signed [W-1:0]        med_a;
	logic signed [W-1:0]        mean_a;
	logic signed [W-1:0]        med_b;
	logic signed [W-1:0]        mean_b;
	logic [1:0]                 feed_ok;
	logic [1:0][W-1:0]          feed_val;
	logic [1:0]                 feed_last;
	logic signed [W-1:0]        y;
	logic [1:0]                 k2;
	logic [NS-1:0][W-1:0]       s2_val;
	logic [NS-1:0]              s2_last;
	logic [1:0]                 n1;

	always_comb begin
		a_ok       = 1'b0;
		a_cnt      = 2'd1;
		a0         = x_s1;
		a1         = x_s1;
		a2         = x_s1;
		a_last     = 1'b0;
		b_ok       = 1'b0;
		raw_seen_d = raw_seen_q;
		raw0_d     = raw0_q;
		raw1_d     = raw1_q;

		unique case (raw_seen_q)
			2'd0: begin
				if (fin_s1) begin
					a_ok   = 1'b1;
					a_last = 1'b1;
				end else begin
					raw1_d     = x_s1;
					raw_seen_d = 2'd1;
				end
			end
			2'd1: begin
				a_ok  = 1'b1;
				a_cnt = 2'd2;
				a0    = raw1_q;
			end
			default: begin
				a_ok  = 1'b1;
				a_cnt = 2'd3;
				a0    = raw0_q;
				a1    = raw1_q;
			end
		endcase

		if (raw_seen_q != 2'd0) begin
			if (fin_s1) begin
				b_ok       = 1'b1;
				raw0_d     = '0;
				raw1_d     = '0;
				raw_seen_d = 2'd0;
			end else begin
				raw0_d     = raw1_q;
				raw1_d     = x_s1;
				raw_seen_d = 2'd2;
			end
		end

		unique case (a_cnt)
			2'd1: begin
				med_a  = a0;
				mean_a = a0;
			end
			2'd2: begin
				med_a  = max2(a0, a1);
				mean_a = mean2(a0, a1);
			end
			default: begin
				med_a  = med3(a0, a1, a2);
				mean_a = mean3(a0, a1, a2);
			end
		endcase
		med_b  = max2(raw1_q, x_s1);
		mean_b = mean2(raw1_q, x_s1);
		n1     = {1'b0, a_ok} + {1'b0, b_ok};

		feed_ok   = {b_ok, a_ok};
		feed_val  = {med_b, med_a};
		feed_last = {1'b1, a_last};

		med_seen_d = med_seen_q;
		med0_d     = med0_q;
		med1_d     = med1_q;
		k2         = 2'd0;
		s2_val     = '0;
		s2_last    = '0;
		for (int i = 0; i < 2; i++) begin
			y = feed_val[i];
			if (feed_ok[i]) begin
				if (med_seen_d == 2'd0) begin
					if (feed_last[i]) begin
						if (k2 < 2'(NS)) begin
							s2_val[k2]  = y;
							s2_last[k2] = 1'b1;
							k2          = k2 + 2'd1;
						end
					end else begin
						med1_d     = y;
						med_seen_d = 2'd1;
					end
				end else begin
					if (k2 < 2'(NS)) begin
						s2_val[k2]  = (med_seen_d == 2'd1) ? mean2(med1_d, y)
							: mean3(med0_d, med1_d, y);
						s2_last[k2] = 1'b0;
						k2          = k2 + 2'd1;
					end
					if (feed_last[i]) begin
						if (k2 < 2'(NS)) begin
							s2_val[k2]  = mean2(med1_d, y);
							s2_last[k2] = 1'b1;
							k2          = k2 + 2'd1;
						end
						med0_d     = '0;
						med1_d     = '0;
						med_seen_d = 2'd0;
					end else begin
						med0_d     = med1_d;
						med1_d     = y;
						med_seen_d = 2'd2;
					end
				end
			end
		end

		unique case (mode)
			mmwf_pkg::MODE_MEAN: begin
				res_ctl.count = n1;
				res_ctl.last  = {1'b0, 1'b1, a_last};
				res_val       = {x_s1, mean_b, mean_a};
			end
			mmwf_pkg::MODE_MEDIAN: begin
				res_ctl.count = n1;
				res_ctl.last  = {1'b0, 1'b1, a_last};
				res_val       = {x_s1, med_b, med_a};
			end
			default: begin
				res_ctl.count = k2;
				res_ctl.last  = s2_last;
				res_val       = s2_val;
			end
		endcase
	end

endmodule

@@ hw/rtl/mmwf_outq.sv @@
// Result buffer that takes the results of one item at once and hands them out one per cycle while out_stall is low.
module mmwf_outq #(
	parameter int SAMPLE_BITS = mmwf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            load_valid,
	output logic                                            load_ready,
	input  mmwf_pkg::res_ctl_t                              res_ctl,
	input  logic [mmwf_pkg::RES_SLOTS-1:0][SAMPLE_BITS-1:0] res_val,
	output logic                                            out_valid,
	input  logic                                            out_stall,
	output logic [SAMPLE_BITS-1:0]                          filtered,
	output logic                                            is_final_out
);

	localparam int NS = mmwf_pkg::RES_SLOTS;

	logic [mmwf_pkg::CNT_BITS-1:0] cnt_q;
	logic [NS-1:0][SAMPLE_BITS-1:0] val_q;
	logic [NS-1:0]                  last_q;
	logic                           pop;
	logic                           load;

	always_comb begin
		out_valid    = cnt_q != '0;
		pop          = out_valid && !out_stall;
		load_ready   = (cnt_q == '0) || ((cnt_q == 2'd1) && pop);
		load         = load_valid && load_ready;
		filtered     = val_q[0];
		is_final_out = last_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res_ctl.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q  <= res_val;
			last_q <= res_ctl.last;
		end else if (pop) begin
			for (int i = 0; i < NS - 1; i++) begin
				val_q[i]  <= val_q[i+1];
				last_q[i] <= last_q[i+1];
			end
		end
	end

endmodule

@@ hw/rtl/median_and_mean_window_filter_unit.sv @@
// Top level of the three-point median and moving-mean window filter.
// Accepted items pass the input register of the core and are loaded into the result buffer,
// which offers the results. The filter takes one item per cycle while each item yields at most
// one result and out_stall is low; an item that yields two or three results holds the input
// while the single result port drains the buffer. Reset clears mode and windows.
module median_and_mean_window_filter_unit #(
	parameter int SAMPLE_BITS = mmwf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mmwf_pkg::MODE_BITS-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [SAMPLE_BITS-1:0]         sample,
	input  logic                           is_final,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [SAMPLE_BITS-1:0]         filtered,
	output logic                           is_final_out
);

	logic [mmwf_pkg::MODE_BITS-1:0]                  mode_q;
	logic                                            load_valid;
	logic                                            load_ready;
	mmwf_pkg::res_ctl_t                              res_ctl;
	logic [mmwf_pkg::RES_SLOTS-1:0][SAMPLE_BITS-1:0] res_val;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mmwf_pkg::MODE_MEAN;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	mmwf_core #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.is_final  (is_final),
		.load_ready(load_ready),
		.load_valid(load_valid),
		.res_ctl   (res_ctl),
		.res_val   (res_val)
	);

	mmwf_outq #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (load_valid),
		.load_ready  (load_ready),
		.res_ctl     (res_ctl),
		.res_val     (res_val),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.filtered    (filtered),
		.is_final_out(is_final_out)
	);

endmodule
